// ===== hdl/stk_pkg.sv =====
// Shared types and constants for the array stack with search.
`timescale 1ns / 1ps

package stk_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 3;
  localparam int WHERE_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_UPDATE = 3'd2,
    FN_VIEW   = 3'd3,
    FN_SEARCH = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // what every cell of the chain does in a cycle
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_WRITE = 3'd3,
    OP_ROT   = 3'd4
  } cell_op_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

endpackage

// ===== hdl/stk_if.sv =====
// Request and result channel interfaces of the stack.
`timescale 1ns / 1ps

interface stk_in_if;
  logic                             valid;
  logic                             ready;
  logic [stk_pkg::FUNC_W-1:0]       func;
  logic signed [stk_pkg::DATA_W-1:0] value;
  logic [stk_pkg::POS_W-1:0]        position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface stk_out_if;
  logic                              valid;
  logic                              ready;
  logic [stk_pkg::STAT_W-1:0]        status;
  logic signed [stk_pkg::DATA_W-1:0] item;
  logic [stk_pkg::WHERE_W-1:0]       where;
  logic                              last;

  modport source (output valid, status, item, where, last, input ready);
  modport sink   (input valid, status, item, where, last, output ready);
endinterface

// ===== hdl/stk_cell.sv =====
// One stack entry; shifts, writes or rotates with its neighbors.
`timescale 1ns / 1ps

module stk_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                              clk,
  input  stk_pkg::cell_op_t                 op,
  input  logic [IW-1:0]                     sel,
  input  logic signed [stk_pkg::DATA_W-1:0] above_d,
  input  logic signed [stk_pkg::DATA_W-1:0] below_d,
  input  logic signed [stk_pkg::DATA_W-1:0] top_d,
  input  logic signed [stk_pkg::DATA_W-1:0] ins_d,
  output logic signed [stk_pkg::DATA_W-1:0] q
);

  logic signed [stk_pkg::DATA_W-1:0] q_r, q_nxt;
  logic                              hit;

  assign hit = (sel == IW'(IDX));

  always_comb begin
    case (op)
      stk_pkg::OP_HOLD:  q_nxt = q_r;
      stk_pkg::OP_PUSH:  q_nxt = above_d;
      stk_pkg::OP_POP:   q_nxt = below_d;
      stk_pkg::OP_WRITE: q_nxt = hit ? ins_d : q_r;
      // lowest occupied cell takes the top entry, the rest move up
      stk_pkg::OP_ROT:   q_nxt = hit ? top_d : below_d;
      default:           q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== hdl/array_stack_with_search.sv =====
// Top level: stack built as a chain of entry cells, with view and search walk.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------
//  in_ch   | in  | valid / ready  | func, value, position
//  out_ch  | out | valid / ready  | status, item, where, last
//
// Push, pop, update and every empty or refused request: done in the accepting cycle,
// result registered and shown the next cycle.
// View and search rotate the occupied cells through the top once, one step a
// cycle while the result register is free; view gives one result per step.
// A stalled result pauses the rotation; a request is taken only while idle and
// the result register is free or being emptied.
// Reset clears the level and the control state; entry contents are kept.
`timescale 1ns / 1ps

module array_stack_with_search #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stk_in_if.sink     in_ch,
  stk_out_if.source  out_ch
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  stk_pkg::state_t   state_r, state_nxt;
  logic [LW-1:0]     level_r, level_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic              mode_view_r, mode_view_nxt;
  logic signed [stk_pkg::DATA_W-1:0] key_r, key_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     fpos_r, fpos_nxt;

  logic              out_v_r, out_v_nxt;
  stk_pkg::status_t  out_status_r, out_status_nxt;
  logic signed [stk_pkg::DATA_W-1:0] out_item_r, out_item_nxt;
  logic [stk_pkg::WHERE_W-1:0] out_where_r, out_where_nxt;
  logic              out_last_r, out_last_nxt;
  logic              emit;

  stk_pkg::cell_op_t cell_op;
  logic [IW-1:0]     cell_sel;
  logic signed [stk_pkg::DATA_W-1:0] q [DEPTH];

  logic              out_free, acc, empty, full, bad_pos, match, last_step;
  logic [IW-1:0]     lvl_m1;
  logic [stk_pkg::POS_W-1:0] level_ext;

  assign out_free  = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == stk_pkg::S_IDLE) && out_free;
  assign acc       = in_ch.valid && in_ch.ready;
  assign empty     = (level_r == '0);
  assign full      = (level_r == LW'(DEPTH));
  assign level_ext = {{(stk_pkg::POS_W - LW){1'b0}}, level_r};
  assign bad_pos   = (in_ch.position == '0) || (in_ch.position > level_ext);
  assign lvl_m1    = IW'(level_r - LW'(1));
  assign match     = (q[0] == key_r);
  assign last_step = (cnt_r == lvl_m1);

  // chain of entry cells, cell 0 holds the top
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [stk_pkg::DATA_W-1:0] above_d, below_d;
    if (i == 0) begin : g_first
      assign above_d = in_ch.value;
    end else begin : g_mid
      assign above_d = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign below_d = q[i];
    end else begin : g_more
      assign below_d = q[i+1];
    end
    stk_cell #(.IDX(i), .IW(IW)) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .sel     (cell_sel),
      .above_d (above_d),
      .below_d (below_d),
      .top_d   (q[0]),
      .ins_d   (in_ch.value),
      .q       (q[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stk_pkg::S_IDLE: begin
        if (acc && !empty &&
            (stk_pkg::func_t'(in_ch.func) == stk_pkg::FN_VIEW ||
             stk_pkg::func_t'(in_ch.func) == stk_pkg::FN_SEARCH)) begin
          state_nxt = stk_pkg::S_WALK;
        end
      end
      stk_pkg::S_WALK: begin
        if (out_free && last_step) begin
          state_nxt = stk_pkg::S_IDLE;
        end
      end
      default: state_nxt = stk_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cell_op        = stk_pkg::OP_HOLD;
    cell_sel       = lvl_m1;
    level_nxt      = level_r;
    cnt_nxt        = cnt_r;
    mode_view_nxt  = mode_view_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    fpos_nxt       = fpos_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_where_nxt  = out_where_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      stk_pkg::S_IDLE: begin
        if (acc) begin
          out_status_nxt = stk_pkg::ST_OK;
          out_item_nxt   = '0;
          out_where_nxt  = '0;
          out_last_nxt   = 1'b1;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          fpos_nxt       = '0;
          key_nxt        = in_ch.value;
          case (stk_pkg::func_t'(in_ch.func))
            stk_pkg::FN_PUSH: begin
              emit = 1'b1;
              if (full) begin
                out_status_nxt = stk_pkg::ST_FULL;
              end else begin
                cell_op   = stk_pkg::OP_PUSH;
                level_nxt = level_r + LW'(1);
              end
            end
            stk_pkg::FN_POP: begin
              emit = 1'b1;
              if (empty) begin
                out_status_nxt = stk_pkg::ST_EMPTY;
              end else begin
                cell_op      = stk_pkg::OP_POP;
                level_nxt    = level_r - LW'(1);
                out_item_nxt = q[0];
              end
            end
            stk_pkg::FN_UPDATE: begin
              emit     = 1'b1;
              cell_sel = IW'(in_ch.position - stk_pkg::POS_W'(1));
              if (empty) begin
                out_status_nxt = stk_pkg::ST_EMPTY;
              end else if (bad_pos) begin
                out_status_nxt = stk_pkg::ST_BADPOS;
              end else begin
                cell_op = stk_pkg::OP_WRITE;
              end
            end
            stk_pkg::FN_VIEW, stk_pkg::FN_SEARCH: begin
              mode_view_nxt = (stk_pkg::func_t'(in_ch.func) == stk_pkg::FN_VIEW);
              if (empty) begin
                emit           = 1'b1;
                out_status_nxt = stk_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      stk_pkg::S_WALK: begin
        if (out_free) begin
          cell_op = stk_pkg::OP_ROT;
          cnt_nxt = cnt_r + IW'(1);
          if (match && !found_r) begin
            found_nxt = 1'b1;
            fpos_nxt  = cnt_r;
          end
          if (mode_view_r) begin
            emit           = 1'b1;
            out_status_nxt = stk_pkg::ST_OK;
            out_item_nxt   = q[0];
            out_where_nxt  = stk_pkg::WHERE_W'(cnt_r) + stk_pkg::WHERE_W'(1);
            out_last_nxt   = last_step;
          end else if (last_step) begin
            emit         = 1'b1;
            out_item_nxt = '0;
            out_last_nxt = 1'b1;
            if (found_r) begin
              out_status_nxt = stk_pkg::ST_OK;
              out_where_nxt  = stk_pkg::WHERE_W'(fpos_r) + stk_pkg::WHERE_W'(1);
            end else if (match) begin
              out_status_nxt = stk_pkg::ST_OK;
              out_where_nxt  = stk_pkg::WHERE_W'(cnt_r) + stk_pkg::WHERE_W'(1);
            end else begin
              out_status_nxt = stk_pkg::ST_NOTFOUND;
              out_where_nxt  = '0;
            end
          end
        end
      end
      default: ;
    endcase
    out_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stk_pkg::S_IDLE;
      level_r <= '0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_view_r  <= mode_view_nxt;
    key_r        <= key_nxt;
    fpos_r       <= fpos_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_where_r  <= out_where_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.status = out_status_r;
  assign out_ch.item   = out_item_r;
  assign out_ch.where  = out_where_r;
  assign out_ch.last   = out_last_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(DEPTH))
    else $error("stack level beyond depth");

  a_walk_level: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stk_pkg::S_WALK |=> $stable(level_r))
    else $error("level moved during a walk");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stk_pkg::S_WALK |-> !empty)
    else $error("walk on an empty stack");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_status_r != stk_pkg::ST_OK |-> out_last_r)
    else $error("refused request result without last");

endmodule
